### rtl/h264_parameter_set_parser_unit_defines.svh
// Assertion macros for the parameter set parser.
// Used by hps_engine; no other dependencies.
`ifndef H264_PARAMETER_SET_PARSER_UNIT_DEFINES_SVH
`define H264_PARAMETER_SET_PARSER_UNIT_DEFINES_SVH

// Plain property, checked on every clock outside reset.
`define HPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define HPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hps_pkg.sv
// Shared types, syntax element numbers and helpers of the parameter set parser.
// No dependencies.
`default_nettype none

package hps_pkg;

  localparam int unsigned MAX_CODE_BITS = 32;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
  } word_t;

  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  localparam logic [5:0] S_REF     = 6'd0;
  localparam logic [5:0] S_TYPE    = 6'd1;
  localparam logic [5:0] S_SKIP    = 6'd1;
  localparam logic [5:0] S_PROFILE = 6'd2;
  localparam logic [5:0] S_LEVEL   = 6'd3;
  localparam logic [5:0] S_SPS_ID  = 6'd4;
  localparam logic [5:0] S_CHROMA  = 6'd5;
  localparam logic [5:0] S_SEP     = 6'd6;
  localparam logic [5:0] S_BDL     = 6'd7;
  localparam logic [5:0] S_BDC     = 6'd8;
  localparam logic [5:0] S_BYPASS  = 6'd9;
  localparam logic [5:0] S_SCALING = 6'd10;
  localparam logic [5:0] S_LOG2FN  = 6'd11;
  localparam logic [5:0] S_POCT    = 6'd12;
  localparam logic [5:0] S_LOG2POC = 6'd13;
  localparam logic [5:0] S_NREF    = 6'd14;
  localparam logic [5:0] S_GAPS    = 6'd15;
  localparam logic [5:0] S_WIDTH   = 6'd16;
  localparam logic [5:0] S_HEIGHT  = 6'd17;
  localparam logic [5:0] S_FONLY   = 6'd18;
  localparam logic [5:0] S_MBAFF   = 6'd19;
  localparam logic [5:0] S_D8X8    = 6'd20;
  localparam logic [5:0] S_CROP    = 6'd21;
  localparam logic [5:0] S_CROPOFS = 6'd22;
  localparam logic [5:0] S_VUI     = 6'd26;
  localparam logic [5:0] S_HMBS    = 6'd27;
  localparam logic [5:0] S_PPS_ID  = 6'd28;
  localparam logic [5:0] S_PPS_SPS = 6'd29;
  localparam logic [5:0] S_ENTROPY = 6'd30;
  localparam logic [5:0] S_POCP    = 6'd31;
  localparam logic [5:0] S_NSG     = 6'd32;
  localparam logic [5:0] S_NREF0   = 6'd33;
  localparam logic [5:0] S_NREF1   = 6'd34;
  localparam logic [5:0] S_WP      = 6'd35;
  localparam logic [5:0] S_WBI     = 6'd36;
  localparam logic [5:0] S_QP      = 6'd37;
  localparam logic [5:0] S_QS      = 6'd38;
  localparam logic [5:0] S_CQP     = 6'd39;
  localparam logic [5:0] S_DBK     = 6'd40;
  localparam logic [5:0] S_CIP     = 6'd41;
  localparam logic [5:0] S_RPC     = 6'd42;

  function automatic logic [32:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 33'h0_FFFF_FFFF : s;
  endfunction

  function automatic logic is_high(logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 || p == 8'd44 ||
           p == 8'd83 || p == 8'd86 || p == 8'd118 || p == 8'd128;
  endfunction

  function automatic logic is_flag(logic [5:0] s);
    return s == S_SEP || s == S_BYPASS || s == S_SCALING || s == S_GAPS || s == S_FONLY ||
           s == S_MBAFF || s == S_D8X8 || s == S_CROP || s == S_VUI || s == S_ENTROPY ||
           s == S_POCP || s == S_WP || s == S_DBK || s == S_CIP || s == S_RPC;
  endfunction

endpackage

`default_nettype wire

### rtl/hps_queue.sv
// Front part: takes NAL words, tags header words, holds them in a two-entry queue.
// Depends on hps_pkg.
`default_nettype none

module hps_queue
  import hps_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] nal_byte_i,
  input  wire logic       nal_start_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            q_valid_o,
  output word_t           q_word_o,
  input  wire logic       q_pop_i
);

  word_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_word_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = q_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: nal_byte_i, hdr: nal_start_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/hps_engine.sv
// Back part: bit-serial Exp-Golomb parser of SPS/PPS syntax with an output register.
// Depends on hps_pkg and the assertion macro header.
`default_nettype none
`include "h264_parameter_set_parser_unit_defines.svh"

module hps_engine
  import hps_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  word_t             q_word_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [5:0]        element_id_o,
  output logic signed [32:0] element_value_o,
  output logic [1:0]        parse_status_o,
  output logic              last_element_o
);

  logic [5:0]  step_q, step_d, lz_q, lz_d;
  logic [31:0] acc_q, acc_d, hmu_q, hmu_d;
  logic [4:0]  kind_q, kind_d;
  logic        active_q, active_d, high_q, high_d, c444_q, c444_d, fonly_q, fonly_d;
  logic [2:0]  crop_q, crop_d, cnt_q, cnt_d;
  logic        pend_q, pend_d;
  word_t       cur_q;
  logic        cur_valid_q, cur_valid_d;

  logic        ov_q, ov_d, olast_q, olast_d;
  logic [5:0]  oid_q, oid_d;
  logic [32:0] oval_q, oval_d;
  logic [1:0]  ost_q, ost_d;

  logic        go, done, emit, fin, bit_v;
  logic [5:0]  e_id, cur_id;
  logic [32:0] e_val, sat_v, sv;
  logic [1:0]  e_st;
  logic        e_last;
  logic [31:0] raw, accn;
  logic [2:0]  t2;

  assign out_valid_o     = ov_q;
  assign element_id_o    = oid_q;
  assign element_value_o = oval_q;
  assign parse_status_o  = ost_q;
  assign last_element_o  = olast_q;

  always_comb begin
    step_d = step_q; lz_d = lz_q; acc_d = acc_q; hmu_d = hmu_q; kind_d = kind_q;
    active_d = active_q; high_d = high_q; c444_d = c444_q; fonly_d = fonly_q;
    crop_d = crop_q; cnt_d = cnt_q; pend_d = pend_q;
    emit = 1'b0; e_id = '0; e_val = '0; e_st = ST_OK; e_last = 1'b0;
    done = 1'b0; fin = 1'b0; raw = '0; accn = '0; t2 = '0; sat_v = '0; sv = '0;
    bit_v = cur_q.data[3'd7 - cnt_q];
    cur_id = (step_q == S_CROPOFS) ? S_CROPOFS + {4'd0, crop_q[1:0]} : step_q;
    go = cur_valid_q && (!ov_q || out_ready_i);

    if (go) begin
      if (pend_q) begin
        emit = 1'b1; e_id = S_HMBS; e_last = 1'b1;
        e_val = fonly_q ? {1'b0, hmu_q} : sat_add(hmu_q, hmu_q);
        active_d = 1'b0; pend_d = 1'b0; done = 1'b1;
      end else if (cur_q.hdr) begin
        if (cnt_q == 3'd0) begin
          step_d = S_REF; lz_d = '0; acc_d = '0; hmu_d = '0; active_d = 1'b0;
          high_d = 1'b0; c444_d = 1'b0; fonly_d = 1'b0; crop_d = '0;
          kind_d = cur_q.data[4:0];
          emit = 1'b1; e_id = S_REF; e_val = {31'd0, cur_q.data[6:5]};
          if (cur_q.data[4:0] == NAL_SPS) begin
            active_d = 1'b1; step_d = S_PROFILE;
          end else if (cur_q.data[4:0] == NAL_PPS) begin
            active_d = 1'b1; step_d = S_PPS_ID;
          end
          cnt_d = 3'd1;
        end else begin
          emit = 1'b1; e_id = S_TYPE; e_val = {28'd0, kind_q};
          e_last = !(kind_q == NAL_SPS || kind_q == NAL_PPS);
          done = 1'b1;
        end
      end else if (!active_q) begin
        done = 1'b1;
      end else if (kind_q == NAL_SPS && step_q < S_SPS_ID) begin
        done = 1'b1;
        if (step_q == S_PROFILE) begin
          emit = 1'b1; e_id = S_PROFILE; e_val = {25'd0, cur_q.data};
          high_d = is_high(cur_q.data); step_d = S_SKIP;
        end else if (step_q == S_SKIP) begin
          step_d = S_LEVEL;
        end else begin
          emit = 1'b1; e_id = S_LEVEL; e_val = {25'd0, cur_q.data}; step_d = S_SPS_ID;
        end
      end else begin
        if (is_flag(step_q)) begin
          raw = {31'd0, bit_v}; fin = 1'b1;
        end else if (step_q == S_WBI) begin
          t2 = {(acc_q == 32'd0) ? 2'b01 : acc_q[1:0], bit_v};
          if (!t2[2]) begin
            acc_d = {29'd0, t2};
          end else begin
            acc_d = '0; raw = {30'd0, t2[1:0]}; fin = 1'b1;
          end
        end else if (acc_q == 32'd0) begin
          if (!bit_v) begin
            if ({1'b0, lz_q} + 7'd1 >= 7'(MAX_CODE_BITS)) begin
              emit = 1'b1; e_id = cur_id; e_st = ST_LONG; e_last = 1'b1; active_d = 1'b0;
            end else begin
              lz_d = lz_q + 6'd1;
            end
          end else if (lz_q == 6'd0) begin
            fin = 1'b1;
          end else begin
            acc_d = 32'd1;
          end
        end else begin
          accn = {acc_q[30:0], bit_v};
          lz_d = lz_q - 6'd1;
          if (lz_q == 6'd1) begin
            acc_d = '0; raw = accn - 32'd1; fin = 1'b1;
          end else begin
            acc_d = accn;
          end
        end

        if (fin) begin
          sv = raw[0] ? (({1'b0, raw} + 33'd1) >> 1) : -({1'b0, raw} >> 1);
          emit = 1'b1; e_id = step_q; e_val = {1'b0, raw};
          unique case (step_q)
            S_SPS_ID: step_d = high_q ? S_CHROMA : S_LOG2FN;
            S_CHROMA: begin
              c444_d = (raw == 32'd3);
              step_d = c444_d ? S_SEP : S_BDL;
            end
            S_SEP:    step_d = S_BDL;
            S_BDL:    begin e_val = sat_add(raw, 32'd8); step_d = S_BDC; end
            S_BDC:    begin e_val = sat_add(raw, 32'd8); step_d = S_BYPASS; end
            S_BYPASS: step_d = S_SCALING;
            S_SCALING, S_POCT: begin
              if (raw != 32'd0) begin
                e_st = ST_UNSUP; e_last = 1'b1; active_d = 1'b0;
              end else begin
                step_d = step_q + 6'd1;
              end
            end
            S_LOG2FN, S_LOG2POC: begin
              e_val = sat_add(raw, 32'd4); step_d = step_q + 6'd1;
            end
            S_NREF, S_GAPS: step_d = step_q + 6'd1;
            S_WIDTH:  begin e_val = sat_add(raw, 32'd1); step_d = S_HEIGHT; end
            S_HEIGHT: begin
              sat_v = sat_add(raw, 32'd1);
              e_val = sat_v; hmu_d = sat_v[31:0]; step_d = S_FONLY;
            end
            S_FONLY:  begin fonly_d = raw[0]; step_d = raw[0] ? S_D8X8 : S_MBAFF; end
            S_MBAFF:  step_d = S_D8X8;
            S_D8X8:   step_d = S_CROP;
            S_CROP:   begin crop_d = '0; step_d = (raw != 32'd0) ? S_CROPOFS : S_VUI; end
            S_CROPOFS: begin
              e_id = cur_id;
              crop_d = crop_q + 3'd1;
              if (crop_d[2]) step_d = S_VUI;
            end
            S_VUI:    pend_d = 1'b1;
            S_PPS_ID, S_PPS_SPS, S_ENTROPY, S_POCP, S_WP, S_DBK, S_CIP, S_WBI:
              step_d = step_q + 6'd1;
            S_NSG: begin
              sat_v = sat_add(raw, 32'd1);
              e_val = sat_v;
              if (sat_v > 33'd1) begin
                e_st = ST_UNSUP; e_last = 1'b1; active_d = 1'b0;
              end else begin
                step_d = S_NREF0;
              end
            end
            S_NREF0, S_NREF1: begin e_val = sat_add(raw, 32'd1); step_d = step_q + 6'd1; end
            S_QP, S_QS: begin e_val = sv + 33'd26; step_d = step_q + 6'd1; end
            S_CQP:    begin e_val = sv; step_d = S_DBK; end
            S_RPC:    begin e_last = 1'b1; active_d = 1'b0; end
            default:  begin emit = 1'b0; active_d = 1'b0; end
          endcase
        end
        done = (cnt_q == 3'd7 && !pend_d) || !active_d;
        cnt_d = cnt_q + 3'd1;
      end
      if (done) cnt_d = 3'd0;
    end

    q_pop_o = q_valid_i && (!cur_valid_q || (go && done));
    cur_valid_d = q_pop_o ? 1'b1 : ((go && done) ? 1'b0 : cur_valid_q);

    ov_d = ov_q; oid_d = oid_q; oval_d = oval_q; ost_d = ost_q; olast_d = olast_q;
    if (emit) begin
      ov_d = 1'b1; oid_d = e_id; oval_d = e_val; ost_d = e_st; olast_d = e_last;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_word_i;
    oid_q   <= oid_d;
    oval_q  <= oval_d;
    ost_q   <= ost_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0; lz_q <= '0; acc_q <= '0; hmu_q <= '0; kind_q <= '0;
      active_q <= 1'b0; high_q <= 1'b0; c444_q <= 1'b0; fonly_q <= 1'b0;
      crop_q <= '0; cnt_q <= '0; pend_q <= 1'b0; cur_valid_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      step_q <= step_d; lz_q <= lz_d; acc_q <= acc_d; hmu_q <= hmu_d; kind_q <= kind_d;
      active_q <= active_d; high_q <= high_d; c444_q <= c444_d; fonly_q <= fonly_d;
      crop_q <= crop_d; cnt_q <= cnt_d; pend_q <= pend_d; cur_valid_q <= cur_valid_d;
      ov_q <= ov_d;
    end
  end

  `HPS_ASSERT_IMP(a_pend_ctx, pend_q, active_q && step_q == S_VUI && cur_valid_q,
                  "height element pending outside VUI step")
  `HPS_ASSERT(a_lz_range, {1'b0, lz_q} < 7'(MAX_CODE_BITS), "zero count overran")
  `HPS_ASSERT_IMP(a_crop_range, crop_q[2], crop_q[1:0] == 2'd0, "crop counter overran")
  `HPS_ASSERT_NXT(a_pend_emit, go && pend_q, ov_q && olast_q && oid_q == S_HMBS,
                  "height element not delivered as last")

endmodule

`default_nettype wire

### rtl/h264_parameter_set_parser_unit.sv
// H.264 SPS/PPS parser: NAL bytes in, numbered syntax elements out (valid/ready).
// Instantiates hps_queue (front) and hps_engine (back); depends on hps_pkg.
//
// A header byte gives two words out, an SPS profile, constraint or level byte is
// taken whole, and every other SPS/PPS byte goes one bitstream bit per cycle
// through the bit-serial Exp-Golomb engine unless the output stalls; the VUI flag
// adds a step for the trailing height word, and the byte that ends a parse leaves
// right after its last element. Bytes outside a parse are dropped. A two-word
// queue decouples input from the engine; the engine writes a registered output
// word and holds, on any bit, in every cycle in which that word waits untaken.
`default_nettype none

module h264_parameter_set_parser_unit
  import hps_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    nal_byte_i,
  input  wire logic          nal_start_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic [5:0]         element_id_o,
  output logic signed [32:0] element_value_o,
  output logic [1:0]         parse_status_o,
  output logic               last_element_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i
);

  logic  q_valid, q_pop;
  word_t q_word;

  hps_queue u_queue (
    .clk_i, .rst_ni, .nal_byte_i, .nal_start_i, .in_valid_i, .in_ready_o,
    .q_valid_o (q_valid), .q_word_o (q_word), .q_pop_i (q_pop)
  );

  hps_engine u_engine (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid), .q_word_i (q_word), .q_pop_o (q_pop),
    .out_valid_o, .out_ready_i, .element_id_o, .element_value_o,
    .parse_status_o, .last_element_o
  );

endmodule

`default_nettype wire
